### hw/rtl/lfsgd_pkg.sv
// Shared types, codes and helpers for the latent factor SGD update core.
`timescale 1ns / 1ps
package lfsgd_pkg;

   localparam int DefaultFactors  = 16;
   localparam int DefaultNumUsers = 1024;
   localparam int DefaultNumItems = 1024;

   localparam logic [1:0] OP_LOAD    = 2'd0;
   localparam logic [1:0] OP_PREDICT = 2'd1;
   localparam logic [1:0] OP_TRAIN   = 2'd2;
   localparam logic [1:0] OP_EPOCH   = 2'd3;

   localparam logic REG_INITIAL_RATE = 1'b0;
   localparam logic REG_REG_WEIGHT   = 1'b1;

   localparam logic [15:0] RATE_RESET   = 16'd655;
   localparam logic [15:0] WEIGHT_RESET = 16'd655;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_MISSING = 1'b1;

   typedef struct packed {
      logic in_ready;
      logic load_wr;
      logic clear_wr;
      logic acc_clr;
      logic dot_mul;
      logic dot_acc;
      logic eval;
      logic upd_cap;
      logic upd_a;
      logic upd_b;
      logic upd_c;
      logic upd_sel;
      logic upd_wr;
      logic epoch_a;
      logic epoch_b;
      logic res_ok_zero;
      logic res_miss;
      logic out_load;
   } lfsgd_cmd_type;

   typedef struct packed {
      logic       in_valid;
      logic [1:0] opcode;
      logic       missing;
      logic       out_free;
   } lfsgd_sts_type;

   function automatic logic signed [15:0] sat16(input logic signed [63:0] x);
      logic signed [15:0] r;
      if (x > 64'sd32767) begin
         r = 16'sh7FFF;
      end else if (x < -64'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = x[15:0];
      end
      return r;
   endfunction

endpackage

### hw/rtl/lfsgd_if.sv
// Request and response channel interfaces of the latent factor SGD update core.
`timescale 1ns / 1ps
interface lfsgd_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         opcode;
   logic [9:0]         user_index;
   logic [9:0]         item_index;
   logic               load_target;
   logic [3:0]         element_index;
   logic signed [15:0] factor_value;
   logic [2:0]         rating;

   modport source (output valid, opcode, user_index, item_index, load_target,
                   element_index, factor_value, rating, input ready);
   modport sink (input valid, opcode, user_index, item_index, load_target,
                 element_index, factor_value, rating, output ready);
endinterface

interface lfsgd_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] value;
   logic               status;

   modport source (output valid, value, status, input ready);
   modport sink (input valid, value, status, output ready);
endinterface

### hw/rtl/lfsgd_ram.sv
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
module lfsgd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

### hw/rtl/lfsgd_ctrl.sv
// Controller state machine of the latent factor SGD update core.
`timescale 1ns / 1ps
module lfsgd_ctrl
   import lfsgd_pkg::*;
#(
   parameter int FACTORS   = DefaultFactors,
   parameter int NUM_USERS = DefaultNumUsers,
   parameter int NUM_ITEMS = DefaultNumItems,
   localparam int KW       = (FACTORS > 1) ? $clog2(FACTORS) : 1,
   localparam int MAXD     = (NUM_USERS > NUM_ITEMS) ? NUM_USERS : NUM_ITEMS,
   localparam int CW       = $clog2(MAXD)
) (
   input  logic          clock,
   input  logic          reset,
   input  lfsgd_sts_type sts,
   output lfsgd_cmd_type cmd,
   output logic [KW-1:0] k_index,
   output logic [CW-1:0] clear_index
);
   localparam logic [3:0] S_CLEAR   = 4'd0;
   localparam logic [3:0] S_IDLE    = 4'd1;
   localparam logic [3:0] S_DECODE  = 4'd2;
   localparam logic [3:0] S_CHECK   = 4'd3;
   localparam logic [3:0] S_DOT_RD  = 4'd4;
   localparam logic [3:0] S_DOT_MUL = 4'd5;
   localparam logic [3:0] S_DOT_ACC = 4'd6;
   localparam logic [3:0] S_EVAL    = 4'd7;
   localparam logic [3:0] S_UPD_RD  = 4'd8;
   localparam logic [3:0] S_UPD_CAP = 4'd9;
   localparam logic [3:0] S_U_A     = 4'd10;
   localparam logic [3:0] S_U_B     = 4'd11;
   localparam logic [3:0] S_U_C     = 4'd12;
   localparam logic [3:0] S_I_A     = 4'd13;
   localparam logic [3:0] S_I_B     = 4'd14;
   localparam logic [3:0] S_I_C     = 4'd15;

   logic [3:0]    state_ff, state_in;
   logic [KW-1:0] k_ff, k_in;
   logic [CW-1:0] clr_ff, clr_in;
   logic          epoch_ff, epoch_in;
   logic          done_ff, done_in;
   logic          k_last;

   assign k_last = (k_ff == KW'(FACTORS - 1));

   always_comb begin
      state_in  = state_ff;
      k_in      = k_ff;
      clr_in    = clr_ff;
      epoch_in  = 1'b0;
      done_in   = done_ff;
      cmd       = '0;
      if (epoch_ff) begin
         cmd.epoch_b = 1'b1;
      end
      if (done_ff) begin
         if (sts.out_free) begin
            cmd.out_load = 1'b1;
            done_in      = 1'b0;
            state_in     = S_IDLE;
         end
      end else begin
         case (state_ff)
            S_CLEAR: begin
               cmd.clear_wr = 1'b1;
               clr_in       = clr_ff + CW'(1);
               if (clr_ff == CW'(MAXD - 1)) begin
                  state_in = S_IDLE;
               end
            end
            S_IDLE: begin
               cmd.in_ready = 1'b1;
               if (sts.in_valid) begin
                  state_in = S_DECODE;
               end
            end
            S_DECODE: begin
               case (sts.opcode)
                  OP_LOAD: begin
                     cmd.load_wr     = 1'b1;
                     cmd.res_ok_zero = 1'b1;
                     done_in         = 1'b1;
                  end
                  OP_EPOCH: begin
                     cmd.epoch_a     = 1'b1;
                     cmd.res_ok_zero = 1'b1;
                     epoch_in        = 1'b1;
                     done_in         = 1'b1;
                  end
                  default: begin
                     state_in = S_CHECK;
                  end
               endcase
            end
            S_CHECK: begin
               if (sts.missing) begin
                  cmd.res_miss = 1'b1;
                  done_in      = 1'b1;
               end else begin
                  cmd.acc_clr = 1'b1;
                  k_in        = '0;
                  state_in    = S_DOT_RD;
               end
            end
            S_DOT_RD: state_in = S_DOT_MUL;
            S_DOT_MUL: begin
               cmd.dot_mul = 1'b1;
               state_in    = S_DOT_ACC;
            end
            S_DOT_ACC: begin
               cmd.dot_acc = 1'b1;
               if (k_last) begin
                  state_in = S_EVAL;
               end else begin
                  k_in     = k_ff + KW'(1);
                  state_in = S_DOT_RD;
               end
            end
            S_EVAL: begin
               cmd.eval = 1'b1;
               k_in     = '0;
               if (sts.opcode == OP_TRAIN) begin
                  state_in = S_UPD_RD;
               end else begin
                  done_in = 1'b1;
               end
            end
            S_UPD_RD: state_in = S_UPD_CAP;
            S_UPD_CAP: begin
               cmd.upd_cap = 1'b1;
               state_in    = S_U_A;
            end
            S_U_A: begin
               cmd.upd_a = 1'b1;
               state_in  = S_U_B;
            end
            S_U_B: begin
               cmd.upd_b = 1'b1;
               state_in  = S_U_C;
            end
            S_U_C: begin
               cmd.upd_c = 1'b1;
               state_in  = S_I_A;
            end
            S_I_A: begin
               cmd.upd_a   = 1'b1;
               cmd.upd_sel = 1'b1;
               state_in    = S_I_B;
            end
            S_I_B: begin
               cmd.upd_b   = 1'b1;
               cmd.upd_sel = 1'b1;
               state_in    = S_I_C;
            end
            S_I_C: begin
               cmd.upd_c   = 1'b1;
               cmd.upd_sel = 1'b1;
               cmd.upd_wr  = 1'b1;
               if (k_last) begin
                  done_in = 1'b1;
               end else begin
                  k_in     = k_ff + KW'(1);
                  state_in = S_UPD_RD;
               end
            end
            default: state_in = S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         k_ff      <= '0;
         clr_ff    <= '0;
         epoch_ff  <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         k_ff      <= k_in;
         clr_ff    <= clr_in;
         epoch_ff  <= epoch_in;
         done_ff   <= done_in;
      end
   end

   assign k_index     = k_ff;
   assign clear_index = clr_ff;

   a_reset_clears: assert property (@(posedge clock) reset |=> state_ff == S_CLEAR)
      else $error("controller did not enter clearing pass after reset");
   a_transfer_decodes: assert property (@(posedge clock) disable iff (reset)
      (cmd.in_ready && sts.in_valid) |=> state_ff == S_DECODE)
      else $error("accepted transfer not decoded");
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> sts.out_free)
      else $error("result loaded over a pending transfer");
endmodule

### hw/rtl/lfsgd_datapath.sv
// Datapath of the latent factor SGD update core: tables, arithmetic, result register.
`timescale 1ns / 1ps
module lfsgd_datapath
   import lfsgd_pkg::*;
#(
   parameter int FACTORS   = DefaultFactors,
   parameter int NUM_USERS = DefaultNumUsers,
   parameter int NUM_ITEMS = DefaultNumItems,
   localparam int KW       = (FACTORS > 1) ? $clog2(FACTORS) : 1,
   localparam int MAXD     = (NUM_USERS > NUM_ITEMS) ? NUM_USERS : NUM_ITEMS,
   localparam int CW       = $clog2(MAXD),
   localparam int UAW      = $clog2(NUM_USERS),
   localparam int IAW      = $clog2(NUM_ITEMS),
   localparam int UFAW     = $clog2(NUM_USERS * FACTORS),
   localparam int IFAW     = $clog2(NUM_ITEMS * FACTORS),
   localparam int ACCW     = 33 + KW
) (
   input  logic          clock,
   input  logic          reset,
   lfsgd_req_if.sink     req_ch,
   lfsgd_rsp_if.source   rsp_ch,
   input  logic          csr_write_enable,
   input  logic          csr_index,
   input  logic [15:0]   csr_write_data,
   input  lfsgd_cmd_type cmd,
   input  logic [KW-1:0] k_index,
   input  logic [CW-1:0] clear_index,
   output lfsgd_sts_type sts
);
   logic [1:0]         op_ff;
   logic [9:0]         user_ff, item_ff;
   logic               tgt_ff;
   logic [3:0]         el_ff;
   logic signed [15:0] fv_ff;
   logic [2:0]         rating_ff;

   logic [15:0] weight_ff, rate_ff, rate_in;

   logic               u_in_range, i_in_range, el_in_range, load_user, load_item;
   logic               uv_rd, iv_rd;
   logic               uv_we, iv_we;
   logic [UAW-1:0]     uv_waddr;
   logic [IAW-1:0]     iv_waddr;
   logic               clr_u, clr_i;
   logic [31:0]        u_base, i_base;
   logic [UFAW-1:0]    uf_raddr, uf_waddr;
   logic [IFAW-1:0]    if_raddr, if_waddr;
   logic               uf_we, if_we;
   logic signed [15:0] uf_rd, if_rd, uf_wdata, if_wdata;

   logic signed [31:0]     prod_ff;
   logic signed [ACCW-1:0] acc_ff, pred_r;
   logic signed [ACCW+1:0] rt_ext, acc_ext, full, err_r;
   logic signed [15:0]     e_ff, value_ff;
   logic                   status_ff;

   logic signed [15:0] x_ff, y_ff, own, other, newv;
   logic signed [31:0] pa_ff;
   logic signed [32:0] pb_ff;
   logic signed [36:0] grad;
   logic signed [53:0] pc_ff, rsum;
   logic signed [21:0] delta;

   logic [19:0] ev, ev_ff;
   logic [40:0] ep_prod_ff;
   logic [16:0] q0, q;
   logic [20:0] rem;

   logic               rsp_valid_ff;
   logic signed [15:0] rsp_value_ff;
   logic               rsp_status_ff;

   assign req_ch.ready = cmd.in_ready;

   always_ff @(posedge clock) begin
      if (cmd.in_ready && req_ch.valid) begin
         op_ff     <= req_ch.opcode;
         user_ff   <= req_ch.user_index;
         item_ff   <= req_ch.item_index;
         tgt_ff    <= req_ch.load_target;
         el_ff     <= req_ch.element_index;
         fv_ff     <= req_ch.factor_value;
         rating_ff <= req_ch.rating;
      end
   end

   assign u_in_range  = 32'(user_ff) < NUM_USERS;
   assign i_in_range  = 32'(item_ff) < NUM_ITEMS;
   assign el_in_range = 32'(el_ff) < FACTORS;
   assign load_user   = cmd.load_wr && el_in_range && !tgt_ff && u_in_range;
   assign load_item   = cmd.load_wr && el_in_range && tgt_ff && i_in_range;

   assign clr_u    = cmd.clear_wr && (32'(clear_index) < NUM_USERS);
   assign clr_i    = cmd.clear_wr && (32'(clear_index) < NUM_ITEMS);
   assign uv_we    = clr_u || load_user;
   assign iv_we    = clr_i || load_item;
   assign uv_waddr = cmd.clear_wr ? UAW'(clear_index) : UAW'(user_ff);
   assign iv_waddr = cmd.clear_wr ? IAW'(clear_index) : IAW'(item_ff);

   lfsgd_ram #(.WIDTH(1), .DEPTH(NUM_USERS)) u_user_valid (
      .clock(clock), .we(uv_we), .waddr(uv_waddr), .wdata(!cmd.clear_wr),
      .raddr(UAW'(user_ff)), .rdata(uv_rd)
   );
   lfsgd_ram #(.WIDTH(1), .DEPTH(NUM_ITEMS)) u_item_valid (
      .clock(clock), .we(iv_we), .waddr(iv_waddr), .wdata(!cmd.clear_wr),
      .raddr(IAW'(item_ff)), .rdata(iv_rd)
   );

   assign u_base   = 32'(user_ff) * FACTORS;
   assign i_base   = 32'(item_ff) * FACTORS;
   assign uf_raddr = UFAW'(u_base + 32'(k_index));
   assign if_raddr = IFAW'(i_base + 32'(k_index));
   assign uf_waddr = cmd.upd_wr ? uf_raddr : UFAW'(u_base + 32'(el_ff));
   assign if_waddr = cmd.upd_wr ? if_raddr : IFAW'(i_base + 32'(el_ff));
   assign uf_we    = cmd.upd_wr || load_user;
   assign if_we    = cmd.upd_wr || load_item;
   assign uf_wdata = cmd.upd_wr ? x_ff : fv_ff;
   assign if_wdata = cmd.upd_wr ? newv : fv_ff;

   lfsgd_ram #(.WIDTH(16), .DEPTH(NUM_USERS * FACTORS)) u_user_factors (
      .clock(clock), .we(uf_we), .waddr(uf_waddr), .wdata(uf_wdata),
      .raddr(uf_raddr), .rdata(uf_rd)
   );
   lfsgd_ram #(.WIDTH(16), .DEPTH(NUM_ITEMS * FACTORS)) u_item_factors (
      .clock(clock), .we(if_we), .waddr(if_waddr), .wdata(if_wdata),
      .raddr(if_raddr), .rdata(if_rd)
   );

   assign pred_r  = (acc_ff + ACCW'(2048)) >>> 12;
   assign rt_ext  = (ACCW+2)'({rating_ff, 24'd0});
   assign acc_ext = (ACCW+2)'(acc_ff);
   assign full    = rt_ext - acc_ext;
   assign err_r   = (full + (ACCW+2)'(2048)) >>> 12;

   always_ff @(posedge clock) begin
      if (cmd.dot_mul) begin
         prod_ff <= uf_rd * if_rd;
      end
      if (cmd.acc_clr) begin
         acc_ff <= '0;
      end else if (cmd.dot_acc) begin
         acc_ff <= acc_ff + ACCW'(prod_ff);
      end
      if (cmd.eval) begin
         e_ff <= sat16(64'(err_r));
      end
      if (cmd.eval) begin
         value_ff  <= (op_ff == OP_TRAIN) ? sat16(64'(err_r)) : sat16(64'(pred_r));
         status_ff <= STATUS_OK;
      end else if (cmd.res_ok_zero) begin
         value_ff  <= '0;
         status_ff <= STATUS_OK;
      end else if (cmd.res_miss) begin
         value_ff  <= '0;
         status_ff <= STATUS_MISSING;
      end
   end

   assign own   = cmd.upd_sel ? y_ff : x_ff;
   assign other = cmd.upd_sel ? x_ff : y_ff;
   assign grad  = (37'(pa_ff) <<< 4) - 37'(pb_ff);
   assign rsum  = pc_ff + 54'sd2147483648;
   assign delta = rsum[53:32];
   assign newv  = sat16(64'(own) + 64'(delta));

   always_ff @(posedge clock) begin
      if (cmd.upd_cap) begin
         x_ff <= uf_rd;
         y_ff <= if_rd;
      end else if (cmd.upd_c) begin
         if (cmd.upd_sel) begin
            y_ff <= newv;
         end else begin
            x_ff <= newv;
         end
      end
      if (cmd.upd_a) begin
         pa_ff <= e_ff * other;
         pb_ff <= $signed({1'b0, weight_ff}) * own;
      end
      if (cmd.upd_b) begin
         pc_ff <= $signed({1'b0, rate_ff}) * grad;
      end
   end

   assign ev  = 20'({rate_ff, 3'b000}) + 20'(rate_ff) + 20'd5;
   assign q0  = ep_prod_ff[40:24];
   assign rem = 21'(ev_ff) - 21'(q0) * 21'd10;
   assign q   = (rem >= 21'd10) ? q0 + 17'd1 : q0;

   always_ff @(posedge clock) begin
      if (cmd.epoch_a) begin
         ev_ff      <= ev;
         ep_prod_ff <= 41'(ev) * 41'd1677721;
      end
   end

   always_comb begin
      rate_in = rate_ff;
      if (csr_write_enable && csr_index == REG_INITIAL_RATE) begin
         rate_in = csr_write_data;
      end else if (cmd.epoch_b) begin
         rate_in = q[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff    <= WEIGHT_RESET;
         rate_ff      <= RATE_RESET;
      end else begin
         rate_ff <= rate_in;
         if (csr_write_enable && csr_index == REG_REG_WEIGHT) begin
            weight_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         rsp_value_ff  <= value_ff;
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.value  = rsp_value_ff;
   assign rsp_ch.status = rsp_status_ff;

   assign sts.in_valid = req_ch.valid;
   assign sts.opcode   = op_ff;
   assign sts.missing  = !(u_in_range && i_in_range && uv_rd && iv_rd);
   assign sts.out_free = !rsp_valid_ff || rsp_ch.ready;
endmodule

### hw/rtl/latent_factor_sgd_update_core.sv
// Top level of the latent factor SGD update core.
//
// Requests arrive on req_ch (valid/ready); one response per request leaves on
// rsp_ch. Registers are written through csr_write_enable/csr_index/csr_write_data
// (index 0 initial rate, also reloading the current rate; index 1 regularization).
// Requests are handled one at a time by a controller stepping a shared datapath.
// Each dot-product element steps through read, multiply and accumulate states;
// each element update steps through read and capture, then A, B and C for the
// user factor and again for the item factor, a schedule set by the single read
// port of each factor table and the shared three-stage update multiplier chain.
// After reset the row-valid tables are cleared, one row per cycle, over
// max(NUM_USERS, NUM_ITEMS) rows before the first request is taken.
// A finished response waits in the output register while the next request is
// taken; a stalled receiver holds the controller once the next result is ready.
`timescale 1ns / 1ps
module latent_factor_sgd_update_core
   import lfsgd_pkg::*;
#(
   parameter int FACTORS   = DefaultFactors,
   parameter int NUM_USERS = DefaultNumUsers,
   parameter int NUM_ITEMS = DefaultNumItems,
   localparam int KW       = (FACTORS > 1) ? $clog2(FACTORS) : 1,
   localparam int MAXD     = (NUM_USERS > NUM_ITEMS) ? NUM_USERS : NUM_ITEMS,
   localparam int CW       = $clog2(MAXD)
) (
   input  logic        clock,
   input  logic        reset,
   lfsgd_req_if.sink   req_ch,
   lfsgd_rsp_if.source rsp_ch,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [15:0] csr_write_data
);
   lfsgd_cmd_type cmd;
   lfsgd_sts_type sts;
   logic [KW-1:0] k_index;
   logic [CW-1:0] clear_index;

   lfsgd_ctrl #(.FACTORS(FACTORS), .NUM_USERS(NUM_USERS), .NUM_ITEMS(NUM_ITEMS)) u_ctrl (
      .clock(clock), .reset(reset), .sts(sts), .cmd(cmd),
      .k_index(k_index), .clear_index(clear_index)
   );

   lfsgd_datapath #(.FACTORS(FACTORS), .NUM_USERS(NUM_USERS), .NUM_ITEMS(NUM_ITEMS)) u_dp (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data), .cmd(cmd), .k_index(k_index),
      .clear_index(clear_index), .sts(sts)
   );
endmodule

### test/tb_latent_factor_sgd_update_core.sv
// Self-checking testbench for the latent factor SGD update core: table-driven and random requests.
`timescale 1ns / 1ps
module tb_latent_factor_sgd_update_core;
   import lfsgd_pkg::*;

   localparam int NF = DefaultFactors;
   localparam int NU = DefaultNumUsers;
   localparam int NI = DefaultNumItems;
   localparam int POOL = 12;
   localparam int PHASE_ITEMS = 260;

   typedef struct {
      logic [1:0]         opcode;
      logic [9:0]         user_index;
      logic [9:0]         item_index;
      logic               load_target;
      logic [3:0]         element_index;
      logic signed [15:0] factor_value;
      logic [2:0]         rating;
   } request_type;

   typedef struct {
      logic signed [15:0] value;
      logic               status;
   } score_type;

   typedef struct {
      logic [1:0]         opcode;
      int                 user_index;
      int                 item_index;
      logic               load_target;
      int                 element_index;
      logic signed [15:0] factor_value;
      int                 rating;
      bit                 fill_row;
      bit                 typed;
      logic signed [15:0] exp_value;
      logic               exp_status;
   } table_row_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic csr_index;
   logic [15:0] csr_write_data;

   lfsgd_req_if req_ch ();
   lfsgd_rsp_if rsp_ch ();

   latent_factor_sgd_update_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // predictor state
   logic signed [15:0] user_tab [NU*NF];
   logic signed [15:0] item_tab [NI*NF];
   logic [NF-1:0]      user_loaded [NU];
   logic [NF-1:0]      item_loaded [NI];
   logic [15:0]        rate_now;
   logic [15:0]        rate_init;
   logic [15:0]        lambda;

   score_type pending_scores [$];
   int     mismatches;
   bit     idle_on;
   bit     hold_go;
   int     hold_left;
   int     user_pool [POOL];
   int     item_pool [POOL];

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic signed [15:0] clip_q4_12(input longint x);
      if (x > 32767) return 16'sh7FFF;
      if (x < -32768) return 16'sh8000;
      return x[15:0];
   endfunction

   function automatic longint round_shift(input longint x, input int s);
      return (x + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint dot_rows(input int u, input int it);
      longint acc;
      acc = 0;
      for (int k = 0; k < NF; k++) begin
         acc += longint'(user_tab[u*NF+k]) * longint'(item_tab[it*NF+k]);
      end
      return acc;
   endfunction

   function automatic logic signed [15:0] step_element(input logic signed [15:0] x,
                                                       input logic signed [15:0] e,
                                                       input logic signed [15:0] y);
      longint grad;
      grad = longint'(e) * longint'(y) * 16 - longint'({1'b0, lambda}) * longint'(x);
      return clip_q4_12(longint'(x) +
                        round_shift(longint'({1'b0, rate_now}) * grad, 32));
   endfunction

   function automatic score_type apply_request(input request_type r);
      score_type s;
      int u, it;
      longint full;
      logic signed [15:0] e;
      s.value  = 16'sd0;
      s.status = STATUS_OK;
      u  = r.user_index;
      it = r.item_index;
      case (r.opcode)
         OP_LOAD: begin
            if (r.load_target == 1'b0) begin
               user_tab[u*NF+r.element_index] = r.factor_value;
               user_loaded[u][r.element_index] = 1'b1;
            end else begin
               item_tab[it*NF+r.element_index] = r.factor_value;
               item_loaded[it][r.element_index] = 1'b1;
            end
         end
         OP_PREDICT, OP_TRAIN: begin
            if (user_loaded[u] == '0 || item_loaded[it] == '0) begin
               s.status = STATUS_MISSING;
            end else if (r.opcode == OP_PREDICT) begin
               s.value = clip_q4_12(round_shift(dot_rows(u, it), 12));
            end else begin
               full = longint'(r.rating) * 16777216 - dot_rows(u, it);
               e = clip_q4_12(round_shift(full, 12));
               s.value = e;
               for (int k = 0; k < NF; k++) begin
                  user_tab[u*NF+k] = step_element(user_tab[u*NF+k], e, item_tab[it*NF+k]);
                  item_tab[it*NF+k] = step_element(item_tab[it*NF+k], e, user_tab[u*NF+k]);
               end
            end
         end
         default: begin
            rate_now = 16'((32'(rate_now) * 9 + 5) / 10);
         end
      endcase
      return s;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH %s: got %0d, want %0d at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   // response side: check transfers, stall at random or for a held stretch
   initial begin
      score_type want;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (pending_scores.size() == 0) begin
               report_mismatch("unexpected response", rsp_ch.value, 0);
            end else begin
               want = pending_scores.pop_front();
               if (rsp_ch.value !== want.value) begin
                  report_mismatch("value", rsp_ch.value, want.value);
               end
               if (rsp_ch.status !== want.status) begin
                  report_mismatch("status", rsp_ch.status, want.status);
               end
            end
         end
         if (hold_go) begin
            hold_go = 1'b0;
            hold_left = 600;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= !(idle_on && $urandom_range(0, 99) < 16);
         end
      end
   end

   task automatic send_request(input request_type r, input bit typed,
                               input logic signed [15:0] tv, input logic ts);
      score_type s;
      if (idle_on && $urandom_range(0, 99) < 16) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.opcode        <= r.opcode;
      req_ch.user_index    <= r.user_index;
      req_ch.item_index    <= r.item_index;
      req_ch.load_target   <= r.load_target;
      req_ch.element_index <= r.element_index;
      req_ch.factor_value  <= r.factor_value;
      req_ch.rating        <= r.rating;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      s = apply_request(r);
      if (typed) begin
         s.value  = tv;
         s.status = ts;
      end
      pending_scores = {pending_scores, s};
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (pending_scores.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [15:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      if (idx == REG_INITIAL_RATE) begin
         rate_init = data;
         rate_now  = data;
      end else begin
         lambda = data;
      end
   endtask

   function automatic logic signed [15:0] random_factor();
      if ($urandom_range(0, 9) == 0) return 16'($urandom);
      return 16'(int'($urandom_range(0, 8191)) - 4096);
   endfunction

   task automatic load_row(input logic tgt, input int row, input logic signed [15:0] fv,
                           input bit typed, input bit rand_vals);
      request_type r;
      for (int k = 0; k < NF; k++) begin
         r = '{OP_LOAD, 10'(row), 10'(row), tgt, 4'(k),
               rand_vals ? random_factor() : fv, 3'($urandom)};
         send_request(r, typed, 16'sd0, STATUS_OK);
      end
   endtask

   // any row is fine unless it is valid with unwritten elements
   function automatic int pick_row(input bit is_user);
      int row;
      logic [NF-1:0] m;
      if ($urandom_range(0, 99) < 8) begin
         row = $urandom_range(0, 1023);
         m = is_user ? user_loaded[row] : item_loaded[row];
         if (m == '0 || m == '1) return row;
      end
      return is_user ? user_pool[$urandom_range(0, POOL-1)] :
                       item_pool[$urandom_range(0, POOL-1)];
   endfunction

   task automatic random_request();
      request_type r;
      int pick;
      pick = $urandom_range(0, 99);
      r.user_index    = 10'(pick_row(1'b1));
      r.item_index    = 10'(pick_row(1'b0));
      r.load_target   = $urandom_range(0, 1);
      r.element_index = 4'($urandom);
      r.factor_value  = random_factor();
      r.rating        = 3'($urandom);
      if (pick < 15) begin
         r.opcode = OP_LOAD;
         if ($urandom_range(0, 9) < 3) begin
            r.user_index = 10'($urandom);
            r.item_index = 10'($urandom);
         end
      end else if (pick < 50) begin
         r.opcode = OP_PREDICT;
      end else if (pick < 95) begin
         r.opcode = OP_TRAIN;
      end else begin
         r.opcode = OP_EPOCH;
      end
      send_request(r, 1'b0, 16'sd0, STATUS_OK);
   endtask

   table_row_type script [] = '{
      '{OP_PREDICT, 0, 0, 0, 0, 16'sd0, 0, 0, 1, 16'sd0, STATUS_MISSING},
      '{OP_TRAIN, 5, 5, 0, 0, 16'sd0, 7, 0, 1, 16'sd0, STATUS_MISSING},
      '{OP_LOAD, 0, 0, 0, 0, 16'sh7FFF, 0, 1, 1, 16'sd0, STATUS_OK},
      '{OP_LOAD, 0, 0, 1, 0, 16'sh7FFF, 0, 1, 1, 16'sd0, STATUS_OK},
      '{OP_PREDICT, 0, 0, 0, 0, 16'sd0, 0, 0, 1, 16'sh7FFF, STATUS_OK},
      '{OP_TRAIN, 0, 0, 0, 0, 16'sd0, 0, 0, 1, 16'sh8000, STATUS_OK},
      '{OP_LOAD, 1023, 1023, 0, 0, 16'sh8000, 0, 1, 1, 16'sd0, STATUS_OK},
      '{OP_LOAD, 1023, 1023, 1, 0, 16'sh8000, 0, 1, 1, 16'sd0, STATUS_OK},
      '{OP_PREDICT, 1023, 1023, 0, 0, 16'sd0, 0, 0, 1, 16'sh7FFF, STATUS_OK},
      '{OP_PREDICT, 0, 1023, 0, 0, 16'sd0, 0, 0, 0, 16'sd0, STATUS_OK},
      '{OP_TRAIN, 1023, 1023, 0, 0, 16'sd0, 7, 0, 1, 16'sh8000, STATUS_OK},
      '{OP_PREDICT, 1023, 0, 0, 0, 16'sd0, 0, 0, 0, 16'sd0, STATUS_OK},
      '{OP_EPOCH, 1023, 1023, 1, 15, 16'shFFFF, 7, 0, 1, 16'sd0, STATUS_OK},
      '{OP_PREDICT, 2, 0, 0, 0, 16'sd0, 0, 0, 1, 16'sd0, STATUS_MISSING},
      '{OP_TRAIN, 0, 700, 0, 0, 16'sd0, 3, 0, 1, 16'sd0, STATUS_MISSING},
      '{OP_TRAIN, 0, 1023, 0, 0, 16'sd0, 3, 0, 0, 16'sd0, STATUS_OK},
      '{OP_LOAD, 1, 0, 0, 0, 16'sh0800, 0, 1, 1, 16'sd0, STATUS_OK},
      '{OP_LOAD, 0, 1, 1, 0, 16'sh1000, 0, 1, 1, 16'sd0, STATUS_OK},
      '{OP_PREDICT, 1, 1, 0, 0, 16'sd0, 0, 0, 0, 16'sd0, STATUS_OK},
      '{OP_TRAIN, 1, 1, 0, 0, 16'sd0, 4, 0, 0, 16'sd0, STATUS_OK},
      '{OP_TRAIN, 1, 0, 0, 0, 16'sd0, 1, 0, 0, 16'sd0, STATUS_OK},
      '{OP_EPOCH, 0, 0, 0, 0, 16'sd0, 0, 0, 1, 16'sd0, STATUS_OK},
      '{OP_PREDICT, 1, 1, 0, 0, 16'sd0, 0, 0, 0, 16'sd0, STATUS_OK}
   };

   initial begin
      #20_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      request_type r;
      logic [15:0] rates [5];
      logic [15:0] weights [5];
      mismatches = 0;
      idle_on    = 1'b1;
      hold_go    = 1'b0;
      hold_left  = 0;
      rate_init  = RATE_RESET;
      rate_now   = RATE_RESET;
      lambda     = WEIGHT_RESET;
      for (int i = 0; i < NU; i++) user_loaded[i] = '0;
      for (int i = 0; i < NI; i++) item_loaded[i] = '0;
      clock = 1'b0;
      reset <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_index <= REG_INITIAL_RATE;
      csr_write_data <= '0;
      req_ch.valid <= 1'b0;
      req_ch.opcode <= OP_LOAD;
      req_ch.user_index <= '0;
      req_ch.item_index <= '0;
      req_ch.load_target <= 1'b0;
      req_ch.element_index <= '0;
      req_ch.factor_value <= '0;
      req_ch.rating <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[n]) begin
         if (script[n].fill_row) begin
            load_row(script[n].load_target,
                     script[n].load_target ? script[n].item_index : script[n].user_index,
                     script[n].factor_value, 1'b1, 1'b0);
         end else begin
            r = '{script[n].opcode, 10'(script[n].user_index), 10'(script[n].item_index),
                  script[n].load_target, 4'(script[n].element_index),
                  script[n].factor_value, 3'(script[n].rating)};
            send_request(r, script[n].typed, script[n].exp_value, script[n].exp_status);
         end
      end

      for (int p = 0; p < POOL; p++) begin
         user_pool[p] = (p == 0) ? 1023 : $urandom_range(0, 1023);
         item_pool[p] = (p == 0) ? 0 : $urandom_range(0, 1023);
         load_row(1'b0, user_pool[p], 16'sd0, 1'b0, 1'b1);
         load_row(1'b1, item_pool[p], 16'sd0, 1'b0, 1'b1);
      end

      rates   = '{RATE_RESET, 16'd0, 16'hFFFF, 16'($urandom), 16'd100};
      weights = '{WEIGHT_RESET, 16'd0, 16'hFFFF, 16'($urandom), 16'd30000};
      for (int ph = 0; ph < 5; ph++) begin
         if (ph > 0) begin
            drain();
            write_csr(REG_INITIAL_RATE, rates[ph]);
            write_csr(REG_REG_WEIGHT, weights[ph]);
         end
         idle_on = (ph != 2);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (ph == 1 && n == 20) hold_go = 1'b1;
            if (ph == 3 && n == 100) begin
               req_ch.valid <= 1'b0;
               while (pending_scores.size() != 0) @(posedge clock);
            end
            random_request();
         end
      end

      req_ch.valid <= 1'b0;
      while (pending_scores.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
